### design/led_pkg.sv
// Shared types and constants for the edit distance unit.
// No dependencies; compile first.
package led_pkg;

    localparam int ACT_W  = 2;
    localparam int CH_W   = 8;
    localparam int DIST_W = 7;

    // Request action codes
    localparam logic [ACT_W-1:0] ACT_FIRST   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SECOND  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    // Largest distance the result field can carry
    localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

    typedef logic [ACT_W-1:0]  action_t;
    typedef logic [CH_W-1:0]   char_t;
    typedef logic [DIST_W-1:0] dist_t;

    // Commands from the sequencer to the word store
    typedef struct packed {
        logic app_first;
        logic app_second;
        logic clear;
    } store_cmd_t;

endpackage

### design/led_in_if.sv
// Request channel: valid/ready handshake carrying action and character.
// Depends on led_pkg.
interface led_in_if;
    logic                valid;
    logic                ready;
    led_pkg::action_t    action;
    led_pkg::char_t      ch;

    modport source (output valid, output action, output ch, input ready);
    modport sink   (input valid, input action, input ch, output ready);
endinterface

### design/led_out_if.sv
// Result channel: valid/ready handshake carrying distance and overflow flag.
// Depends on led_pkg.
interface led_out_if;
    logic              valid;
    logic              ready;
    led_pkg::dist_t    distance;
    logic              overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);
endinterface

### design/led_word_store.sv
// Storage for both words, their lengths and the dropped-character flag.
// Depends on led_pkg.
module led_word_store #(
    parameter int MAX_LEN = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  led_pkg::store_cmd_t             cmd,
    input  led_pkg::char_t                  ch,
    input  logic [$clog2(MAX_LEN)-1:0]      first_addr,
    input  logic [$clog2(MAX_LEN)-1:0]      second_addr,
    output led_pkg::char_t                  first_rdata,
    output led_pkg::char_t                  second_rdata,
    output logic [$clog2(MAX_LEN+1)-1:0]    first_len,
    output logic [$clog2(MAX_LEN+1)-1:0]    second_len,
    output logic                            dropped
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);

    led_pkg::char_t first_mem  [0:MAX_LEN-1];
    led_pkg::char_t second_mem [0:MAX_LEN-1];

    logic [LW-1:0] first_len_reg, first_len_next;
    logic [LW-1:0] second_len_reg, second_len_next;
    logic          dropped_reg, dropped_next;
    logic          first_full, second_full;
    logic          first_we, second_we;

    assign first_full  = (first_len_reg == LW'(MAX_LEN));
    assign second_full = (second_len_reg == LW'(MAX_LEN));
    assign first_we    = cmd.app_first && !first_full;
    assign second_we   = cmd.app_second && !second_full;

    always_comb
    begin
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        dropped_next    = dropped_reg;
        if (cmd.clear)
        begin
            first_len_next  = '0;
            second_len_next = '0;
            dropped_next    = 1'b0;
        end
        else
        begin
            if (first_we)
                first_len_next = first_len_reg + LW'(1);
            if (second_we)
                second_len_next = second_len_reg + LW'(1);
            if ((cmd.app_first && first_full) || (cmd.app_second && second_full))
                dropped_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            dropped_reg    <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (first_we)
            first_mem[first_len_reg[AW-1:0]] <= ch;
        if (second_we)
            second_mem[second_len_reg[AW-1:0]] <= ch;
        first_rdata  <= first_mem[first_addr];
        second_rdata <= second_mem[second_addr];
    end

    assign first_len  = first_len_reg;
    assign second_len = second_len_reg;
    assign dropped    = dropped_reg;

endmodule

### design/led_row_mem.sv
// One row of the cost matrix: single write port, registered read port.
// Depends on nothing.
module led_row_mem #(
    parameter int MAX_LEN = 64
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [$clog2(MAX_LEN)-1:0]      waddr,
    input  logic [$clog2(MAX_LEN+1)-1:0]    wdata,
    input  logic [$clog2(MAX_LEN)-1:0]      raddr,
    output logic [$clog2(MAX_LEN+1)-1:0]    rdata
);

    localparam int LW = $clog2(MAX_LEN + 1);

    logic [LW-1:0] row_mem [0:MAX_LEN-1];

    always_ff @(posedge clk)
    begin
        if (we)
            row_mem[waddr] <= wdata;
        rdata <= row_mem[raddr];
    end

endmodule

### design/led_cell_unit.sv
// Shared cell evaluator: minimum of deletion, insertion and substitution cost.
// Depends on nothing.
module led_cell_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic [$clog2(MAX_LEN+1)-1:0]    up,
    input  logic [$clog2(MAX_LEN+1)-1:0]    left,
    input  logic [$clog2(MAX_LEN+1)-1:0]    diag,
    input  logic                            match,
    output logic [$clog2(MAX_LEN+1)-1:0]    cost
);

    localparam int LW = $clog2(MAX_LEN + 1);

    logic [LW:0] up_inc, left_inc, diag_sub, min_a, min_b;

    always_comb
    begin
        up_inc   = {1'b0, up} + (LW+1)'(1);
        left_inc = {1'b0, left} + (LW+1)'(1);
        diag_sub = {1'b0, diag} + (LW+1)'(!match);
        min_a    = (up_inc < left_inc) ? up_inc : left_inc;
        min_b    = (min_a < diag_sub) ? min_a : diag_sub;
        // A cell never exceeds the longer word length, so the top bit drops
        cost     = min_b[LW-1:0];
    end

endmodule

### design/levenshtein_edit_distance_unit.sv
// Top level of the edit distance unit: sequencer, word store, row buffer
// and shared cell evaluator. Depends on led_pkg, led_in_if, led_out_if.
//
//   Channel   Dir   Payload                        Moves
//   request   in    action[1:0], ch[7:0]           one append or compute request
//   result    out   distance[6:0], overflow        one result per compute
//
// Timing: append requests are taken back to back while the sequencer is idle.
// A compute request holds the unit for one setup step per row of the first
// word, each followed by one cell step per column of the second word, all
// through the single cell evaluator and the single read port of the row
// buffer. With either word empty it goes straight to the result. Request
// ready stays low from compute acceptance until the result is registered.
// Reset: asynchronous, active low; clears lengths, flag, sequencer state and
// the result valid flag. The word and row memories need no clearing pass.
// Stalls: the result register holds while result.ready is low; appends are
// still taken, and a further compute waits in its final state until the
// result register frees.
module levenshtein_edit_distance_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    led_in_if.sink      request,
    led_out_if.source   result
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int DW = (LW > led_pkg::DIST_W) ? LW : led_pkg::DIST_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROW  = 2'd1;
    localparam logic [1:0] ST_CELL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] row_reg, row_next;
    logic [AW-1:0] col_reg, col_next;
    logic [LW-1:0] diag_reg, diag_next;
    logic [LW-1:0] left_reg, left_next;
    logic [LW-1:0] dist_reg, dist_next;

    logic           out_valid_reg, out_valid_next;
    led_pkg::dist_t out_dist_reg, out_dist_next;
    logic           out_ovf_reg, out_ovf_next;

    led_pkg::store_cmd_t store_cmd;
    led_pkg::char_t      first_rdata, second_rdata;
    logic [LW-1:0]       first_len, second_len;
    logic                dropped;

    logic          req_fire;
    logic          last_row, last_col;
    logic [AW-1:0] col_raddr;
    logic [LW-1:0] row_rdata, up_val, cell_cost;
    logic          row_we;
    logic          done_fire;
    logic [DW-1:0] dist_ext;
    led_pkg::dist_t dist_sat;

    // Accept requests only while the sequencer is idle
    assign request.ready = (state_reg == ST_IDLE);
    assign req_fire      = request.valid && request.ready;

    assign last_row = ({{(LW-AW){1'b0}}, row_reg} == first_len - LW'(1));
    assign last_col = ({{(LW-AW){1'b0}}, col_reg} == second_len - LW'(1));

    // Row setup fetches column 0; each cell fetches the next column, the last its own
    assign col_raddr = (state_reg == ST_CELL && !last_col) ? col_reg + AW'(1) :
                       (state_reg == ST_CELL)              ? col_reg : '0;

    // The first row reads the implicit initial row j instead of the buffer
    assign up_val = (row_reg == '0) ? ({{(LW-AW){1'b0}}, col_reg} + LW'(1)) : row_rdata;
    assign row_we = (state_reg == ST_CELL);

    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    always_comb
    begin
        store_cmd.app_first  = req_fire && (request.action == led_pkg::ACT_FIRST);
        store_cmd.app_second = req_fire && (request.action == led_pkg::ACT_SECOND);
        store_cmd.clear      = done_fire;
    end

    // Clamp the distance to the result field
    assign dist_ext = DW'(dist_reg);
    assign dist_sat = (dist_ext > DW'(led_pkg::DIST_MAX)) ? led_pkg::DIST_MAX
                                                           : dist_ext[led_pkg::DIST_W-1:0];

    led_word_store #(.MAX_LEN(MAX_LEN)) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (store_cmd),
        .ch           (request.ch),
        .first_addr   (row_reg),
        .second_addr  (col_raddr),
        .first_rdata  (first_rdata),
        .second_rdata (second_rdata),
        .first_len    (first_len),
        .second_len   (second_len),
        .dropped      (dropped)
    );

    led_row_mem #(.MAX_LEN(MAX_LEN)) u_row (
        .clk   (clk),
        .we    (row_we),
        .waddr (col_reg),
        .wdata (cell_cost),
        .raddr (col_raddr),
        .rdata (row_rdata)
    );

    led_cell_unit #(.MAX_LEN(MAX_LEN)) u_cell (
        .up    (up_val),
        .left  (left_reg),
        .diag  (diag_reg),
        .match (first_rdata == second_rdata),
        .cost  (cell_cost)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        diag_next  = diag_reg;
        left_next  = left_reg;
        dist_next  = dist_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && request.action == led_pkg::ACT_COMPUTE)
                begin
                    row_next = '0;
                    if (first_len == '0 || second_len == '0)
                    begin
                        // Empty word: the distance is the other length
                        dist_next  = first_len | second_len;
                        state_next = ST_DONE;
                    end
                    else
                        state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                // Column 0 of this row is i, of the previous row i-1
                diag_next  = {{(LW-AW){1'b0}}, row_reg};
                left_next  = {{(LW-AW){1'b0}}, row_reg} + LW'(1);
                col_next   = '0;
                state_next = ST_CELL;
            end
            ST_CELL:
            begin
                left_next = cell_cost;
                diag_next = up_val;
                if (last_col)
                begin
                    if (last_row)
                    begin
                        dist_next  = cell_cost;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        row_next   = row_reg + AW'(1);
                        state_next = ST_ROW;
                    end
                end
                else
                    col_next = col_reg + AW'(1);
            end
            ST_DONE:
            begin
                if (done_fire)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_dist_next  = out_dist_reg;
        out_ovf_next   = out_ovf_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (done_fire)
        begin
            out_valid_next = 1'b1;
            out_dist_next  = dist_sat;
            out_ovf_next   = dropped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        diag_reg     <= diag_next;
        left_reg     <= left_next;
        dist_reg     <= dist_next;
        out_dist_reg <= out_dist_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.distance = out_dist_reg;
    assign result.overflow = out_ovf_reg;

endmodule

### design/led_checker.sv
// Port-level checks for the edit distance unit, bound to the top level.
// Depends on led_pkg and levenshtein_edit_distance_unit.
module led_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input led_pkg::action_t req_action,
    input logic             res_valid,
    input logic             res_ready,
    input led_pkg::dist_t   res_distance,
    input logic             res_overflow
);

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(res_distance) && $stable(res_overflow)))
        else $error("stalled result changed");

    // A new result only follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(req_ready))
        else $error("result appeared without a compute");

    // A compute request holds off further requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_action == led_pkg::ACT_COMPUTE) |=> !req_ready)
        else $error("ready stayed high after compute");

    // Appends and unused actions leave the unit ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_action != led_pkg::ACT_COMPUTE) |=> req_ready)
        else $error("ready dropped after append");

endmodule

bind levenshtein_edit_distance_unit led_checker u_led_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (request.valid),
    .req_ready    (request.ready),
    .req_action   (request.action),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_distance (result.distance),
    .res_overflow (result.overflow)
);

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for levenshtein_edit_distance_unit: a scoreboard class
// predicts each distance, and tasks drive append and compute requests under random stalls.
// Depends on led_pkg, led_in_if, led_out_if and the unit itself.
module tb;

    localparam int               WORD_CAP     = 64;     // characters each word can hold
    localparam led_pkg::action_t ACT_NONE     = 2'd3;   // unused code, the unit ignores it
    localparam int               CLK_HALF     = 10;
    localparam int               RESET_CYCLES = 10;
    localparam int               ITEM_TARGET  = 1700;   // appends and computes to send
    localparam int               TAIL_ITEMS   = 200;    // last stretch runs without idling
    localparam int               HOLD_AT      = 8;      // result count that starts the long hold
    localparam int               LONG_HOLD    = 400;    // cycles the result side holds off
    // Room for a full 64 x 64 compute with a long receiver hold on top of it,
    // and then for the sum several times over.
    localparam int               STALL_LIMIT  = 20000;
    localparam int               TAIL_CYCLES  = 20;

    typedef struct {
        led_pkg::dist_t distance;
        logic           overflow;
    } outcome_t;

    // Tracks both words as the unit sees them and queues the outcome of
    // every compute request until its result shows up.
    class edit_distance_board;
        led_pkg::char_t first_word[$];
        led_pkg::char_t second_word[$];
        bit             dropped;
        outcome_t       outcomes_due[$];
        int             mismatches;

        function new();
            dropped    = 1'b0;
            mismatches = 0;
        endfunction

        // Single-row dynamic programming over the two words, unit costs.
        function int edit_distance();
            int row [WORD_CAP+1];
            int diag;
            int up;
            int best;
            for (int j = 0; j <= second_word.size(); j++)
                row[j] = j;
            for (int i = 1; i <= first_word.size(); i++)
            begin
                diag   = row[0];
                row[0] = i;
                for (int j = 1; j <= second_word.size(); j++)
                begin
                    up   = row[j];
                    best = (up < row[j-1]) ? up + 1 : row[j-1] + 1;
                    if (diag + (second_word[j-1] != first_word[i-1]) < best)
                        best = diag + (second_word[j-1] != first_word[i-1]);
                    diag   = up;
                    row[j] = best;
                end
            end
            return row[second_word.size()];
        endfunction

        function void note_request(led_pkg::action_t act, led_pkg::char_t c);
            outcome_t o;
            int       d;
            case (act)
                led_pkg::ACT_FIRST:
                    if (first_word.size() < WORD_CAP) first_word = {first_word, c};
                    else dropped = 1'b1;
                led_pkg::ACT_SECOND:
                    if (second_word.size() < WORD_CAP) second_word = {second_word, c};
                    else dropped = 1'b1;
                led_pkg::ACT_COMPUTE:
                begin
                    d = edit_distance();
                    o.distance = (d > int'(led_pkg::DIST_MAX)) ? led_pkg::DIST_MAX
                                                                : led_pkg::dist_t'(d);
                    o.overflow = dropped;
                    outcomes_due = {outcomes_due, o};
                    first_word.delete();
                    second_word.delete();
                    dropped = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(led_pkg::dist_t distance, logic overflow);
            outcome_t o;
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: result with nothing expected: distance %0d overflow %b",
                         $time, distance, overflow);
                mismatches++;
                return;
            end
            o = outcomes_due.pop_front();
            if (distance !== o.distance)
            begin
                $display("%0t: distance mismatch: expected %0d, actual %0d",
                         $time, o.distance, distance);
                mismatches++;
            end
            if (overflow !== o.overflow)
            begin
                $display("%0t: overflow mismatch: expected %b, actual %b",
                         $time, o.overflow, overflow);
                mismatches++;
            end
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    led_in_if  request_bus ();
    led_out_if result_bus ();

    edit_distance_board board;
    int  items_sent;       // appends and computes accepted, ignored codes left out
    bit  sender_idling;    // request side inserts gaps while set
    bit  quiet_tail;       // final stretch: no idling on either side
    bit  long_hold_done;

    levenshtein_edit_distance_unit #(
        .MAX_LEN (WORD_CAP)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_bus),
        .result  (result_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Drop valid and hold the request side idle; n sets the length of the pause.
    task automatic pause_requests(input int n);
        request_bus.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Offer one request and hold it until the unit takes it. Valid stays high
    // after acceptance so back-to-back requests need no extra edge; the next
    // call or a pause decides what the following cycle carries.
    task automatic send_request(input led_pkg::action_t act, input led_pkg::char_t c);
        request_bus.valid  <= 1'b1;
        request_bus.action <= act;
        request_bus.ch     <= c;
        @(posedge clk);
        while (request_bus.ready !== 1'b1) @(posedge clk);
        board.note_request(act, c);
        if (act != ACT_NONE) items_sent++;
        if (!quiet_tail && sender_idling && $urandom_range(0, 3) == 0)
            pause_requests($urandom_range(1, 6));
    endtask

    task automatic send_word(input led_pkg::action_t act, input string text);
        for (int k = 0; k < text.len(); k++)
            send_request(act, led_pkg::char_t'(text[k]));
    endtask

    // Stop offering requests until every predicted result has been seen.
    // Always wait on the clock before checking, so valid is not driven twice in a step.
    task automatic wait_for_results();
        request_bus.valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    // Load a pair of words with interleaved appends, then compute if asked. Characters
    // mostly come from a small random palette so that matches are common;
    // now and then an ignored code slips in between appends.
    task automatic send_pair(input int len1, input int len2, input bit with_compute);
        led_pkg::char_t palette [4];
        bit             wide;
        bit             to_first;
        int             left1;
        int             left2;
        led_pkg::char_t c;
        foreach (palette[k]) palette[k] = led_pkg::char_t'($urandom_range(0, 255));
        wide  = ($urandom_range(0, 3) == 0);
        left1 = len1;
        left2 = len2;
        if ($urandom_range(0, 5) == 0) sender_idling = !sender_idling;
        while (left1 > 0 || left2 > 0)
        begin
            if ($urandom_range(0, 29) == 0)
                send_request(ACT_NONE, led_pkg::char_t'($urandom_range(0, 255)));
            to_first = (left2 == 0) || (left1 > 0 && $urandom_range(0, 1) == 1);
            c = wide ? led_pkg::char_t'($urandom_range(0, 255))
                     : palette[$urandom_range(0, 3)];
            if (to_first)
            begin
                send_request(led_pkg::ACT_FIRST, c);
                left1--;
            end
            else
            begin
                send_request(led_pkg::ACT_SECOND, c);
                left2--;
            end
        end
        if (with_compute)
            send_request(led_pkg::ACT_COMPUTE, led_pkg::char_t'($urandom_range(0, 255)));
    endtask

    // Stimulus: reset, a directed opening, random pairs, then drain.
    initial
    begin : stimulus
        int pair_idx;
        int kind;
        board              = new();
        items_sent         = 0;
        sender_idling      = 1'b1;
        quiet_tail         = 1'b0;
        rst_n              <= 1'b0;
        request_bus.valid  <= 1'b0;
        request_bus.action <= led_pkg::ACT_FIRST;
        request_bus.ch     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: both words empty, an ignored code, one word empty
        // on each side, extreme characters, equal and differing single
        // characters, and a short classic pair with an ignored code inside.
        send_request(led_pkg::ACT_COMPUTE, 8'hFF);
        send_request(ACT_NONE, 8'hFF);
        send_request(led_pkg::ACT_FIRST, 8'h00);
        send_request(led_pkg::ACT_FIRST, 8'hFF);
        send_request(led_pkg::ACT_COMPUTE, 8'h00);
        send_request(led_pkg::ACT_SECOND, 8'h80);
        send_request(led_pkg::ACT_SECOND, 8'h7F);
        send_request(led_pkg::ACT_SECOND, 8'h01);
        send_request(led_pkg::ACT_COMPUTE, 8'hAA);
        send_request(led_pkg::ACT_FIRST, 8'h55);
        send_request(led_pkg::ACT_SECOND, 8'h55);
        send_request(led_pkg::ACT_COMPUTE, 8'h55);
        send_request(led_pkg::ACT_FIRST, 8'h00);
        send_request(led_pkg::ACT_SECOND, 8'hFF);
        send_request(led_pkg::ACT_COMPUTE, 8'h0F);
        send_word(led_pkg::ACT_FIRST, "flaw");
        send_request(ACT_NONE, 8'h00);
        send_word(led_pkg::ACT_SECOND, "lawn");
        send_request(led_pkg::ACT_COMPUTE, 8'hF0);

        // Random pairs. The first two overfill the words so that the largest
        // distance and the dropped-character flag show up early; after that
        // most pairs are short, a few are long, some leave one word empty,
        // and some skip the compute so words run on into the next pair.
        pair_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= ITEM_TARGET - TAIL_ITEMS) quiet_tail = 1'b1;
            kind = $urandom_range(0, 99);
            if (pair_idx == 0)
                send_pair(WORD_CAP + 6, 0, 1'b1);
            else if (pair_idx == 1)
                send_pair(WORD_CAP, WORD_CAP + 2, 1'b1);
            else if (kind < 4)
                send_pair($urandom_range(40, WORD_CAP + 6),
                          $urandom_range(40, WORD_CAP + 6), 1'b1);
            else if (kind < 10)
                send_pair($urandom_range(0, 12), 0, 1'b1);
            else if (kind < 16)
                send_pair(0, $urandom_range(0, 12), 1'b1);
            else if (kind < 21)
                send_pair($urandom_range(0, 6), $urandom_range(0, 6), 1'b0);
            else
                send_pair($urandom_range(0, 10), $urandom_range(0, 10), 1'b1);
            // Once, let the unit empty out completely before going on.
            if (pair_idx == 30) wait_for_results();
            pair_idx++;
        end

        // Close any words left open by a skipped compute, then drain.
        send_request(led_pkg::ACT_COMPUTE, led_pkg::char_t'($urandom_range(0, 255)));
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Result side: check each result as it is taken, and stall in random
    // bursts. Idling switches on and off in stretches; once, at a fixed
    // result count, hold off long enough for the unit to back up its input.
    initial
    begin : result_side
        int  stall_left;
        int  mode_left;
        int  results_seen;
        bit  stalling_on;
        stall_left        = 0;
        mode_left         = 0;
        results_seen      = 0;
        stalling_on       = 1'b1;
        long_hold_done    = 1'b0;
        result_bus.ready  <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                board.check_result(result_bus.distance, result_bus.overflow);
                results_seen++;
            end
            if (mode_left == 0)
            begin
                stalling_on = ($urandom_range(0, 2) != 0);
                mode_left   = $urandom_range(20, 80);
            end
            else
                mode_left--;
            if (results_seen == HOLD_AT && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
            end
            else if (stall_left == 0 && stalling_on && !quiet_tail
                     && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((request_bus.valid === 1'b1 && request_bus.ready === 1'b1) ||
                (result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: timeout, no request or result moved for %0d cycles",
                 $time, STALL_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

endmodule

### sim.f
design/led_pkg.sv
design/led_in_if.sv
design/led_out_if.sv
design/led_word_store.sv
design/led_row_mem.sv
design/led_cell_unit.sv
design/levenshtein_edit_distance_unit.sv
design/led_checker.sv
tb/tb.sv
